>>> design/euler_xyz_to_quaternion_macros.svh
// ---------------------------------------------------------------------------
// euler_xyz_to_quaternion assertion macros
// Concurrent check helpers clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef EULER_XYZ_TO_QUATERNION_MACROS_SVH
`define EULER_XYZ_TO_QUATERNION_MACROS_SVH

// same-cycle implication
`define EXQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EXQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/exq_pkg.sv
// ---------------------------------------------------------------------------
// exq_pkg
// Request types, fixed-point constants and tables for the Euler to
// quaternion pipeline.
// ---------------------------------------------------------------------------
package exq_pkg;

  localparam int AngleFracBits = 6;
  localparam int QuatFracBits  = 15;

  localparam int NumAngles = 3;
  localparam int NumComps  = 4;

  typedef struct packed {
    logic signed [15:0] roll_deg;
    logic signed [15:0] pitch_deg;
    logic signed [15:0] yaw_deg;
  } in_req_t;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } out_req_t;

  // half angle to binary angle: a * 2^(28-F) / 45, rounded
  localparam int PhDiv        = 45;
  localparam int PhShift      = 28 - AngleFracBits;
  localparam int PhRound      = 180 / 8;
  localparam int PhRecipShift = 21;
  localparam int PhRecip      = (2 ** PhRecipShift + PhDiv - 1) / PhDiv;
  localparam int KW           = 32 - PhRecipShift;

  typedef logic [PhShift-1:0] ph_frac_t;
  typedef ph_frac_t ph_tab_t [PhDiv];

  function automatic ph_tab_t ph_tab_build();
    ph_tab_t t;
    for (int r = 0; r < PhDiv; r++) begin
      t[r] = ph_frac_t'(((64'(r) << PhShift) + 64'(PhRound)) / PhDiv);
    end
    return t;
  endfunction

  localparam ph_tab_t PH_FRAC = ph_tab_build();

  // cordic
  localparam int TrigW        = 32;
  localparam int CordicSteps  = 30;
  localparam int CordicPer    = 3;
  localparam int CordicStages = CordicSteps / CordicPer;
  localparam logic signed [TrigW-1:0] CordicGain = 32'sd652032874;

  localparam logic signed [TrigW-1:0] ATAN [CordicSteps] = '{
    32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4, 32'sh028B0D43,
    32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55, 32'sh0028BE53, 32'sh00145F2F,
    32'sh000A2F98, 32'sh000517CC, 32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA,
    32'sh0000517D, 32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518,
    32'sh0000028C, 32'sh00000146, 32'sh000000A3, 32'sh00000051, 32'sh00000029,
    32'sh00000014, 32'sh0000000A, 32'sh00000005, 32'sh00000003, 32'sh00000001
  };

  // products and components
  localparam int ProdW = 2 * TrigW;
  localparam int QW    = TrigW + 1;

  // square root, two result bits per stage
  localparam int SumW     = 64;
  localparam int NormW    = SumW / 2;
  localparam int SqSteps  = NormW;
  localparam int SqPer    = 2;
  localparam int SqStages = SqSteps / SqPer;

  // restoring division, two quotient bits per stage
  localparam int DivBits   = 16;
  localparam int DivPer    = 2;
  localparam int DivStages = DivBits / DivPer;
  localparam int DivW      = QW + QuatFracBits + 1;

  localparam logic signed [15:0] QuatOne =
    (QuatFracBits >= 15) ? 16'sh7FFF : 16'(1 << QuatFracBits);
  localparam logic signed [15:0] SatMax = 16'sh7FFF;
  localparam logic signed [15:0] SatMin = 16'sh8000;

  function automatic logic signed [TrigW-1:0] rnd_q30(input logic signed [ProdW-1:0] p);
    logic signed [ProdW-1:0] t;
    t = (p + 64'sd536870912) >>> 30;
    return t[TrigW-1:0];
  endfunction

endpackage

>>> design/euler_xyz_to_quaternion.sv
// ---------------------------------------------------------------------------
// euler_xyz_to_quaternion
// Throughput: one request per cycle while the output is not stalled; 30 cordic
// steps at 3 per stage, square root and division at 2 result bits per stage
// set the depth.
// A stall at the output while a result is held freezes every stage at once.
// Reset clears the stage valid bits only; no state is kept between requests.
// ---------------------------------------------------------------------------
module euler_xyz_to_quaternion (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  exq_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output exq_pkg::out_req_t out_data
);
  import exq_pkg::*;

  logic adv;
  logic out_valid_r;
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // stage a: magnitude and quotient by 45
  logic                 av_r;
  logic [15:0]          amag_r [NumAngles];
  logic                 aneg_r [NumAngles];
  logic [KW-1:0]        ak_r   [NumAngles];
  logic signed [15:0]   ang    [NumAngles];
  logic [15:0]          amag_nxt [NumAngles];
  logic [KW-1:0]        ak_nxt   [NumAngles];

  assign ang[0] = in_data.roll_deg;
  assign ang[1] = in_data.pitch_deg;
  assign ang[2] = in_data.yaw_deg;

  always_comb begin
    logic [31:0] prod;
    for (int l = 0; l < NumAngles; l++) begin
      amag_nxt[l] = ang[l][15] ? 16'(-ang[l]) : 16'(ang[l]);
      prod        = 32'(amag_nxt[l]) * 32'(PhRecip);
      ak_nxt[l]   = prod[PhRecipShift +: KW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      av_r <= 1'b0;
    end else if (adv) begin
      av_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < NumAngles; l++) begin
        amag_r[l] <= amag_nxt[l];
        aneg_r[l] <= ang[l][15];
        ak_r[l]   <= ak_nxt[l];
      end
    end
  end

  // cordic pipeline
  logic                    cv_r [CordicStages+1];
  logic signed [TrigW-1:0] cx_r [CordicStages+1][NumAngles];
  logic signed [TrigW-1:0] cy_r [CordicStages+1][NumAngles];
  logic signed [TrigW-1:0] cz_r [CordicStages+1][NumAngles];
  logic                    cf_r [CordicStages+1][NumAngles];
  logic signed [TrigW-1:0] z0_nxt [NumAngles];
  logic                    f0_nxt [NumAngles];

  // binary angle of the half angle, folded into the right half plane
  always_comb begin
    logic [15:0] k45;
    logic [5:0]  rem;
    logic [31:0] q;
    logic [31:0] ph;
    for (int l = 0; l < NumAngles; l++) begin
      k45       = 16'(ak_r[l]) * 16'(PhDiv);
      rem       = 6'(amag_r[l] - k45);
      q         = 32'({ak_r[l], PH_FRAC[rem]});
      ph        = aneg_r[l] ? 32'(-q) : q;
      f0_nxt[l] = ph[31] ^ ph[30];
      z0_nxt[l] = $signed({ph[31] ^ f0_nxt[l], ph[30:0]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r[0] <= 1'b0;
    end else if (adv) begin
      cv_r[0] <= av_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < NumAngles; l++) begin
        cx_r[0][l] <= CordicGain;
        cy_r[0][l] <= '0;
        cz_r[0][l] <= z0_nxt[l];
        cf_r[0][l] <= f0_nxt[l];
      end
    end
  end

  for (genvar g = 0; g < CordicStages; g++) begin : g_cordic
    logic signed [TrigW-1:0] x_nxt [NumAngles];
    logic signed [TrigW-1:0] y_nxt [NumAngles];
    logic signed [TrigW-1:0] z_nxt [NumAngles];

    always_comb begin
      logic signed [TrigW-1:0] xt, yt, zt, dx, dy;
      for (int l = 0; l < NumAngles; l++) begin
        xt = cx_r[g][l];
        yt = cy_r[g][l];
        zt = cz_r[g][l];
        for (int j = 0; j < CordicPer; j++) begin
          dx = yt >>> (g * CordicPer + j);
          dy = xt >>> (g * CordicPer + j);
          if (!zt[TrigW-1]) begin
            xt = xt - dx;
            yt = yt + dy;
            zt = zt - ATAN[g * CordicPer + j];
          end else begin
            xt = xt + dx;
            yt = yt - dy;
            zt = zt + ATAN[g * CordicPer + j];
          end
        end
        x_nxt[l] = xt;
        y_nxt[l] = yt;
        z_nxt[l] = zt;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cv_r[g+1] <= 1'b0;
      end else if (adv) begin
        cv_r[g+1] <= cv_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        cx_r[g+1] <= x_nxt;
        cy_r[g+1] <= y_nxt;
        cz_r[g+1] <= z_nxt;
        cf_r[g+1] <= cf_r[g];
      end
    end
  end

  // trig stage: undo the half-plane fold
  logic                    tv_r;
  logic signed [TrigW-1:0] tc_r [NumAngles];
  logic signed [TrigW-1:0] ts_r [NumAngles];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r <= 1'b0;
    end else if (adv) begin
      tv_r <= cv_r[CordicStages];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < NumAngles; l++) begin
        tc_r[l] <= cf_r[CordicStages][l] ? -cx_r[CordicStages][l] : cx_r[CordicStages][l];
        ts_r[l] <= cf_r[CordicStages][l] ? -cy_r[CordicStages][l] : cy_r[CordicStages][l];
      end
    end
  end

  // products: m1 pairs, m2 round, m3 third factor, m4 round and sum
  logic                    m1v_r, m2v_r, m3v_r, m4v_r;
  logic signed [ProdW-1:0] p1_r  [4];
  logic signed [TrigW-1:0] r1_r  [4];
  logic signed [ProdW-1:0] p2_r  [8];
  logic signed [TrigW-1:0] m1cz_r, m1sz_r, m2cz_r, m2sz_r;
  logic signed [QW-1:0]    q_r   [NumComps];
  logic signed [TrigW-1:0] t2    [8];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      t2[i] = rnd_q30(p2_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1v_r <= 1'b0;
      m2v_r <= 1'b0;
      m3v_r <= 1'b0;
      m4v_r <= 1'b0;
    end else if (adv) begin
      m1v_r <= tv_r;
      m2v_r <= m1v_r;
      m3v_r <= m2v_r;
      m4v_r <= m3v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r[0] <= tc_r[0] * tc_r[1];
      p1_r[1] <= ts_r[0] * ts_r[1];
      p1_r[2] <= ts_r[0] * tc_r[1];
      p1_r[3] <= tc_r[0] * ts_r[1];
      m1cz_r  <= tc_r[2];
      m1sz_r  <= ts_r[2];

      for (int i = 0; i < 4; i++) begin
        r1_r[i] <= rnd_q30(p1_r[i]);
      end
      m2cz_r <= m1cz_r;
      m2sz_r <= m1sz_r;

      p2_r[0] <= r1_r[0] * m2cz_r;
      p2_r[1] <= r1_r[1] * m2sz_r;
      p2_r[2] <= r1_r[2] * m2cz_r;
      p2_r[3] <= r1_r[3] * m2sz_r;
      p2_r[4] <= r1_r[3] * m2cz_r;
      p2_r[5] <= r1_r[2] * m2sz_r;
      p2_r[6] <= r1_r[0] * m2sz_r;
      p2_r[7] <= r1_r[1] * m2cz_r;

      q_r[0] <= $signed({t2[0][TrigW-1], t2[0]}) + $signed({t2[1][TrigW-1], t2[1]});
      q_r[1] <= $signed({t2[2][TrigW-1], t2[2]}) - $signed({t2[3][TrigW-1], t2[3]});
      q_r[2] <= $signed({t2[4][TrigW-1], t2[4]}) + $signed({t2[5][TrigW-1], t2[5]});
      q_r[3] <= $signed({t2[6][TrigW-1], t2[6]}) - $signed({t2[7][TrigW-1], t2[7]});
    end
  end

  // sum of squares
  logic                 s1v_r;
  logic [SumW-1:0]      sq_r  [NumComps];
  logic signed [QW-1:0] s1q_r [NumComps];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1v_r <= 1'b0;
    end else if (adv) begin
      s1v_r <= m4v_r;
    end
  end

  always_ff @(posedge clk) begin
    logic [QW-1:0]     qa;
    logic [2*QW-1:0]   full;
    if (adv) begin
      for (int i = 0; i < NumComps; i++) begin
        qa       = q_r[i][QW-1] ? QW'(-q_r[i]) : QW'(q_r[i]);
        full     = qa * qa;
        sq_r[i]  <= full[SumW-1:0];
        s1q_r[i] <= q_r[i];
      end
    end
  end

  // integer square root
  logic                 sv_r  [SqStages+1];
  logic [SumW-1:0]      sval_r [SqStages+1];
  logic [SumW-1:0]      sroot_r [SqStages+1];
  logic signed [QW-1:0] sq_q_r [SqStages+1][NumComps];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r[0] <= 1'b0;
    end else if (adv) begin
      sv_r[0] <= s1v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sval_r[0]  <= sq_r[0] + sq_r[1] + sq_r[2] + sq_r[3];
      sroot_r[0] <= '0;
      sq_q_r[0]  <= s1q_r;
    end
  end

  for (genvar g = 0; g < SqStages; g++) begin : g_sqrt
    logic [SumW-1:0] val_nxt;
    logic [SumW-1:0] root_nxt;

    always_comb begin
      logic [SumW-1:0] v, r, bt, trial;
      v = sval_r[g];
      r = sroot_r[g];
      for (int j = 0; j < SqPer; j++) begin
        bt    = 64'd1 << (SumW - 2 - 2 * (g * SqPer + j));
        trial = r + bt;
        if (v >= trial) begin
          v = v - trial;
          r = (r >> 1) + bt;
        end else begin
          r = r >> 1;
        end
      end
      val_nxt  = v;
      root_nxt = r;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[g+1] <= 1'b0;
      end else if (adv) begin
        sv_r[g+1] <= sv_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sval_r[g+1]  <= val_nxt;
        sroot_r[g+1] <= root_nxt;
        sq_q_r[g+1]  <= sq_q_r[g];
      end
    end
  end

  // division by the norm with rounding
  logic               dv_r    [DivStages+1];
  logic [NormW-1:0]   dn_r    [DivStages+1];
  logic               dzero_r [DivStages+1];
  logic [DivW-1:0]    drem_r  [DivStages+1][NumComps];
  logic [DivBits-1:0] dq_r    [DivStages+1][NumComps];
  logic               dovf_r  [DivStages+1][NumComps];
  logic               dneg_r  [DivStages+1][NumComps];
  logic [NormW-1:0]   norm;

  assign norm = sroot_r[SqStages][NormW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (adv) begin
      dv_r[0] <= sv_r[SqStages];
    end
  end

  always_ff @(posedge clk) begin
    logic [QW-1:0]   qm;
    logic [DivW-1:0] dd;
    if (adv) begin
      dn_r[0]    <= norm;
      dzero_r[0] <= (norm == '0);
      for (int i = 0; i < NumComps; i++) begin
        qm = sq_q_r[SqStages][i][QW-1] ? QW'(-sq_q_r[SqStages][i])
                                        : QW'(sq_q_r[SqStages][i]);
        dd = DivW'({qm, {QuatFracBits{1'b0}}}) + DivW'(norm >> 1);
        drem_r[0][i] <= dd;
        dq_r[0][i]   <= '0;
        dovf_r[0][i] <= (dd >= DivW'({norm, {DivBits{1'b0}}}));
        dneg_r[0][i] <= sq_q_r[SqStages][i][QW-1];
      end
    end
  end

  for (genvar g = 0; g < DivStages; g++) begin : g_div
    logic [DivW-1:0]    rem_nxt [NumComps];
    logic [DivBits-1:0] quo_nxt [NumComps];

    always_comb begin
      logic [DivW-1:0]    rm, sub;
      logic [DivBits-1:0] qo;
      for (int i = 0; i < NumComps; i++) begin
        rm = drem_r[g][i];
        qo = dq_r[g][i];
        for (int j = 0; j < DivPer; j++) begin
          sub = DivW'(dn_r[g]) << (DivBits - 1 - (g * DivPer + j));
          if (rm >= sub) begin
            rm = rm - sub;
            qo[DivBits - 1 - (g * DivPer + j)] = 1'b1;
          end
        end
        rem_nxt[i] = rm;
        quo_nxt[i] = qo;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[g+1] <= 1'b0;
      end else if (adv) begin
        dv_r[g+1] <= dv_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dn_r[g+1]    <= dn_r[g];
        dzero_r[g+1] <= dzero_r[g];
        drem_r[g+1]  <= rem_nxt;
        dq_r[g+1]    <= quo_nxt;
        dovf_r[g+1]  <= dovf_r[g];
        dneg_r[g+1]  <= dneg_r[g];
      end
    end
  end

  // saturation and output register
  out_req_t           out_data_r;
  logic signed [15:0] comp [NumComps];

  always_comb begin
    logic [DivBits-1:0] qv;
    for (int i = 0; i < NumComps; i++) begin
      qv = dq_r[DivStages][i];
      if (dovf_r[DivStages][i]) begin
        comp[i] = dneg_r[DivStages][i] ? SatMin : SatMax;
      end else if (dneg_r[DivStages][i]) begin
        comp[i] = (qv > 16'd32768) ? SatMin : 16'(-qv);
      end else begin
        comp[i] = (qv > 16'd32767) ? SatMax : 16'(qv);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_r[DivStages];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (dzero_r[DivStages]) begin
        out_data_r.quat_w <= QuatOne;
        out_data_r.quat_x <= '0;
        out_data_r.quat_y <= '0;
        out_data_r.quat_z <= '0;
      end else begin
        out_data_r.quat_w <= comp[0];
        out_data_r.quat_x <= comp[1];
        out_data_r.quat_y <= comp[2];
        out_data_r.quat_z <= comp[3];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`include "euler_xyz_to_quaternion_macros.svh"

  `EXQ_ASSERT_NXT(a_enter, in_valid && !in_stall, av_r, "accepted request missing in stage a")
  `EXQ_ASSERT_IMP(a_out_src, $rose(out_valid_r), $past(dv_r[DivStages]), "result without request")
  `EXQ_ASSERT_NXT(a_freeze, out_valid_r && out_stall && dv_r[0], dv_r[0], "stalled stage lost request")

endmodule
